// ===== hw/rtl/pit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WORK = 2'd1,
        PH_BUZZ = 2'd2
    } phase_t;

    localparam logic CFG_WORK_SECONDS = 1'b0;
    localparam logic CFG_BUZZ_TENTHS  = 1'b1;

    localparam int WORK_W   = 13;
    localparam int BUZZ_W   = 10;
    localparam int COUNT_W  = 16;
    localparam int SHOWN_W  = 17;
    localparam int SECS_W   = 13;
    localparam int MIN_W    = 8;

    localparam logic [MIN_W-1:0]  MAX_MINUTES = 8'd99;
    localparam logic [19:0]       RECIP_10    = 20'd838861;
    localparam logic [13:0]       RECIP_60    = 14'd8739;

    // v < 100: tens digit by reciprocal multiply
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(tens_of(v)) * 7'd10;
        return v[3:0] - t[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/phase_interval_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Three-phase interval timer (idle, work, buzz) counted in tenths of a second.
// A tick word (op 0) counts the running phase down and produces no output; a
// refresh word (op 1) produces one output word with the time as decimal digits,
// the buzzer level and the phase seen before it, and starts the work phase if
// start_pressed is set while idle. Both kinds of word are taken one per cycle
// while in_stall is low; timer state updates in the accept cycle and each
// refresh result goes through a five-stage digit pipeline (capture, divide
// by ten, divide by sixty and remainder, saturation, digit split). Input
// stall rises only when all five stages hold words and the output is stalled.
// Config writes apply at the next phase load, or at once to the idle readout.
module phase_interval_timer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic        start_pressed,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       minutes_tens,
    output logic [3:0]       minutes_ones,
    output logic [2:0]       seconds_tens,
    output logic [3:0]       seconds_ones,
    output logic [3:0]       tenths_digit,
    output logic             buzzer_on,
    output logic [1:0]       phase
);

    logic [pit_pkg::WORK_W-1:0]  work_seconds_reg;
    logic [pit_pkg::BUZZ_W-1:0]  buzz_tenths_reg;
    pit_pkg::phase_t             phase_reg, phase_next;
    logic [pit_pkg::COUNT_W-1:0] remaining_reg, remaining_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic accept, running;

    logic [pit_pkg::SHOWN_W-1:0] work_full;
    logic [pit_pkg::COUNT_W-1:0] work_load;
    logic [pit_pkg::SHOWN_W-1:0] shown;

    logic [pit_pkg::SHOWN_W-1:0] shown1_reg;
    pit_pkg::phase_t             ph1_reg, ph2_reg, ph3_reg, ph4_reg;
    logic [pit_pkg::SECS_W-1:0]  q10_2_reg, q10_3_reg;
    logic [3:0]                  lo2_reg;
    logic [3:0]                  tenths3_reg, tenths4_reg;
    logic [pit_pkg::MIN_W-1:0]   min3_reg;
    logic [6:0]                  min4_reg;
    logic [5:0]                  sec4_reg;

    logic [36:0]                 prod10;
    logic [26:0]                 prod60;
    logic [7:0]                  q10x10;
    logic [13:0]                 min_x60;
    logic [6:0]                  min_sat;

    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign accept   = in_valid && rdy1;
    assign running  = (phase_reg == pit_pkg::PH_WORK) || (phase_reg == pit_pkg::PH_BUZZ);

    assign work_full = (pit_pkg::SHOWN_W'(work_seconds_reg) << 3)
                     + (pit_pkg::SHOWN_W'(work_seconds_reg) << 1);
    assign work_load = work_full[pit_pkg::SHOWN_W-1] ? {pit_pkg::COUNT_W{1'b1}}
                                                     : work_full[pit_pkg::COUNT_W-1:0];
    assign shown     = running ? pit_pkg::SHOWN_W'(remaining_reg) : work_full;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        if (accept)
        begin
            if (!op)
            begin
                if (running)
                begin
                    if (remaining_reg <= pit_pkg::COUNT_W'(1))
                    begin
                        if (phase_reg == pit_pkg::PH_WORK)
                        begin
                            phase_next     = pit_pkg::PH_BUZZ;
                            remaining_next = pit_pkg::COUNT_W'(buzz_tenths_reg);
                        end
                        else
                        begin
                            phase_next     = pit_pkg::PH_WORK;
                            remaining_next = work_load;
                        end
                    end
                    else
                    begin
                        remaining_next = remaining_reg - pit_pkg::COUNT_W'(1);
                    end
                end
            end
            else if (!running && start_pressed)
            begin
                phase_next     = pit_pkg::PH_WORK;
                remaining_next = work_load;
            end
        end
    end

    assign prod10  = 37'(shown1_reg) * 37'(pit_pkg::RECIP_10);
    assign prod60  = 27'(q10_2_reg) * 27'(pit_pkg::RECIP_60);
    assign q10x10  = 8'(q10_2_reg[3:0]) * 8'd10;
    assign min_x60 = 14'(min3_reg) * 14'd60;
    assign min_sat = (min4_reg > 7'(pit_pkg::MAX_MINUTES)) ? 7'(pit_pkg::MAX_MINUTES)
                                                           : min4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_seconds_reg <= pit_pkg::WORK_W'(60);
            buzz_tenths_reg  <= pit_pkg::BUZZ_W'(10);
            phase_reg        <= pit_pkg::PH_IDLE;
            remaining_reg    <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pit_pkg::CFG_WORK_SECONDS: work_seconds_reg <= cfg_data;
                    pit_pkg::CFG_BUZZ_TENTHS:  buzz_tenths_reg  <= cfg_data[pit_pkg::BUZZ_W-1:0];
                    default: ;
                endcase
            end
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            if (rdy1) v1_reg <= in_valid && op;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            shown1_reg <= shown;
            ph1_reg    <= phase_reg;
        end
        if (rdy2)
        begin
            q10_2_reg <= prod10[35:23];
            lo2_reg   <= shown1_reg[3:0];
            ph2_reg   <= ph1_reg;
        end
        if (rdy3)
        begin
            min3_reg    <= prod60[26:19];
            q10_3_reg   <= q10_2_reg;
            tenths3_reg <= lo2_reg - q10x10[3:0];
            ph3_reg     <= ph2_reg;
        end
        if (rdy4)
        begin
            min4_reg    <= (min3_reg > pit_pkg::MAX_MINUTES) ? 7'(pit_pkg::MAX_MINUTES)
                                                             : min3_reg[6:0];
            sec4_reg    <= q10_3_reg[5:0] - min_x60[5:0];
            tenths4_reg <= tenths3_reg;
            ph4_reg     <= ph3_reg;
        end
        if (rdy5)
        begin
            minutes_tens <= pit_pkg::tens_of(min_sat);
            minutes_ones <= pit_pkg::ones_of(min_sat);
            seconds_tens <= 3'(pit_pkg::tens_of(7'(sec4_reg)));
            seconds_ones <= pit_pkg::ones_of(7'(sec4_reg));
            tenths_digit <= tenths4_reg;
            buzzer_on    <= (ph4_reg == pit_pkg::PH_BUZZ);
            phase        <= ph4_reg;
        end
    end

    assign out_valid = v5_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pit_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pit_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] minutes_tens,
    input wire logic [3:0] minutes_ones,
    input wire logic [2:0] seconds_tens,
    input wire logic [3:0] seconds_ones,
    input wire logic [3:0] tenths_digit,
    input wire logic       buzzer_on,
    input wire logic [1:0] phase
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(minutes_tens) && $stable(minutes_ones)
            && $stable(seconds_tens) && $stable(seconds_ones) && $stable(tenths_digit)
            && $stable(phase) && $stable(buzzer_on))
        else $error("output word changed while stalled");

    a_buzz_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> buzzer_on == (phase == pit_pkg::PH_BUZZ))
        else $error("buzzer level disagrees with phase");

    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> minutes_tens <= 4'd9 && minutes_ones <= 4'd9 && seconds_tens <= 3'd5
            && seconds_ones <= 4'd9 && tenths_digit <= 4'd9)
        else $error("digit out of range");

    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase != 2'd3)
        else $error("illegal phase code");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind phase_interval_timer pit_checker u_pit_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .minutes_tens (minutes_tens),
    .minutes_ones (minutes_ones),
    .seconds_tens (seconds_tens),
    .seconds_ones (seconds_ones),
    .tenths_digit (tenths_digit),
    .buzzer_on    (buzzer_on),
    .phase        (phase)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    typedef struct packed {
        logic [3:0]      mins_tens;
        logic [3:0]      mins_ones;
        logic [2:0]      secs_tens;
        logic [3:0]      secs_ones;
        logic [3:0]      tenths;
        logic            buzz;
        pit_pkg::phase_t ph;
    } readout_t;

    class timer_tracker;
        logic [pit_pkg::WORK_W-1:0]  work_s;
        logic [pit_pkg::BUZZ_W-1:0]  buzz_t;
        pit_pkg::phase_t             ph;
        logic [pit_pkg::COUNT_W-1:0] remain;
        readout_t                    due_readouts[$];
        int                          errors;
        int                          ticks;
        int                          refreshes;
        int                          buzz_entries;

        function new();
            work_s = 13'd60;
            buzz_t = 10'd10;
            ph = pit_pkg::PH_IDLE;
            remain = '0;
            errors = 0;
            ticks = 0;
            refreshes = 0;
            buzz_entries = 0;
        endfunction

        function void set_reg(logic idx, logic [12:0] value);
            if (idx == pit_pkg::CFG_WORK_SECONDS)
                work_s = value;
            else
                buzz_t = value[pit_pkg::BUZZ_W-1:0];
        endfunction

        function logic [pit_pkg::COUNT_W-1:0] work_count();
            int unsigned t;
            t = work_s * 10;
            return (t > 32'hFFFF) ? 16'hFFFF : t[pit_pkg::COUNT_W-1:0];
        endfunction

        function void note_word(logic w_op, logic w_start);
            int unsigned shown;
            int unsigned mins;
            int unsigned secs;
            readout_t r;
            if (w_op == OP_TICK)
            begin
                ticks++;
                if (ph == pit_pkg::PH_WORK || ph == pit_pkg::PH_BUZZ)
                begin
                    if (remain <= 1)
                    begin
                        if (ph == pit_pkg::PH_WORK)
                        begin
                            ph = pit_pkg::PH_BUZZ;
                            remain = pit_pkg::COUNT_W'(buzz_t);
                            buzz_entries++;
                        end
                        else
                        begin
                            ph = pit_pkg::PH_WORK;
                            remain = work_count();
                        end
                    end
                    else
                    begin
                        remain = remain - 1'b1;
                    end
                end
                return;
            end
            refreshes++;
            r.ph = ph;
            r.buzz = (ph == pit_pkg::PH_BUZZ);
            if (ph == pit_pkg::PH_WORK || ph == pit_pkg::PH_BUZZ)
            begin
                shown = remain;
            end
            else
            begin
                shown = work_s * 10;
                if (w_start)
                begin
                    remain = work_count();
                    ph = pit_pkg::PH_WORK;
                end
            end
            mins = shown / 600;
            if (mins > 99)
                mins = 99;
            secs = (shown / 10) % 60;
            r.mins_tens = 4'(mins / 10);
            r.mins_ones = 4'(mins % 10);
            r.secs_tens = 3'(secs / 10);
            r.secs_ones = 4'(secs % 10);
            r.tenths = 4'(shown % 10);
            due_readouts.push_back(r);
        endfunction

        function int diff(string name, int unsigned e, int unsigned a);
            if (e == a)
                return 0;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            return 1;
        endfunction

        function void check_readout(readout_t got);
            readout_t exp_r;
            if (due_readouts.size() == 0)
            begin
                $display("%0t: readout with none expected, got %h", $time, got);
                errors++;
                return;
            end
            exp_r = due_readouts.pop_front();
            errors += diff("minutes_tens", exp_r.mins_tens, got.mins_tens);
            errors += diff("minutes_ones", exp_r.mins_ones, got.mins_ones);
            errors += diff("seconds_tens", exp_r.secs_tens, got.secs_tens);
            errors += diff("seconds_ones", exp_r.secs_ones, got.secs_ones);
            errors += diff("tenths_digit", exp_r.tenths, got.tenths);
            errors += diff("buzzer_on", exp_r.buzz, got.buzz);
            errors += diff("phase", int'(exp_r.ph), int'(got.ph));
        endfunction

        function int pending();
            return due_readouts.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic        start_pressed;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  minutes_tens;
    logic [3:0]  minutes_ones;
    logic [2:0]  seconds_tens;
    logic [3:0]  seconds_ones;
    logic [3:0]  tenths_digit;
    logic        buzzer_on;
    logic [1:0]  phase;

    timer_tracker tracker;
    int          stall_mode = 0;
    int          stall_left = 0;
    int unsigned cyc = 0;

    phase_interval_timer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .start_pressed(start_pressed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .minutes_tens (minutes_tens),
        .minutes_ones (minutes_ones),
        .seconds_tens (seconds_tens),
        .seconds_ones (seconds_ones),
        .tenths_digit (tenths_digit),
        .buzzer_on    (buzzer_on),
        .phase        (phase)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        readout_t got;
        if (rst_n)
        begin
            if (cfg_we)
                tracker.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                tracker.note_word(op, start_pressed);
            if (out_valid && !out_stall)
            begin
                got.mins_tens = minutes_tens;
                got.mins_ones = minutes_ones;
                got.secs_tens = seconds_tens;
                got.secs_ones = seconds_ones;
                got.tenths = tenths_digit;
                got.buzz = buzzer_on;
                got.ph = pit_pkg::phase_t'(phase);
                tracker.check_readout(got);
            end
        end
    end

    always @(negedge clk)
    begin
        cyc++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 99) < 30);
            2: out_stall = ($urandom_range(0, 99) < 75);
            default: out_stall = cyc[2];
        endcase
    end

    task automatic send_word(logic w_op, logic w_start);
        in_valid = 1'b1;
        op = w_op;
        start_pressed = w_start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause(int n);
        in_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = 13'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // drain outstanding readouts, then let the digit pipeline empty
    task automatic settle();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic random_run(int n, int tick_pct);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                send_word(($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_REFRESH,
                          1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 7));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = 1'b0;
        start_pressed = 1'b0;
        tracker = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle display at reset durations, ignored start on a tick
        send_word(OP_REFRESH, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_REFRESH, 1'b0);
        settle();
        write_reg(pit_pkg::CFG_WORK_SECONDS, 5999);
        write_reg(pit_pkg::CFG_BUZZ_TENTHS, 600);
        send_word(OP_REFRESH, 1'b0);
        settle();
        write_reg(pit_pkg::CFG_WORK_SECONDS, 1);
        write_reg(pit_pkg::CFG_BUZZ_TENTHS, 1);
        send_word(OP_REFRESH, 1'b1);
        send_word(OP_REFRESH, 1'b1);
        repeat (9) send_word(OP_TICK, 1'b0);
        send_word(OP_REFRESH, 1'b0);
        send_word(OP_TICK, 1'b0);
        send_word(OP_REFRESH, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_REFRESH, 1'b0);

        settle();
        write_reg(pit_pkg::CFG_WORK_SECONDS, $urandom_range(1, 4));
        write_reg(pit_pkg::CFG_BUZZ_TENTHS, $urandom_range(1, 40));
        random_run(150, 70);

        settle();
        write_reg(pit_pkg::CFG_WORK_SECONDS, 1);
        write_reg(pit_pkg::CFG_BUZZ_TENTHS, 1);
        random_run(150, 60);

        settle();
        write_reg(pit_pkg::CFG_WORK_SECONDS, $urandom_range(1, 8));
        write_reg(pit_pkg::CFG_BUZZ_TENTHS, $urandom_range(1, 80));
        random_run(150, 75);

        settle();
        write_reg(pit_pkg::CFG_WORK_SECONDS, 5999);
        write_reg(pit_pkg::CFG_BUZZ_TENTHS, 600);
        random_run(300, 90);

        settle();
        if (tracker.pending() != 0)
            tracker.errors++;
        $display("Run covered %0d ticks and %0d refreshes over several duration settings;",
                 tracker.ticks, tracker.refreshes);
        $display("the buzz phase was entered %0d times, with %0d mismatches.",
                 tracker.buzz_entries, tracker.errors);
        if (tracker.errors == 0)
            $display("phase_interval_timer test passed");
        else
            $display("phase_interval_timer test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("phase_interval_timer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pit_pkg.sv
hw/rtl/phase_interval_timer.sv
hw/rtl/pit_checker.sv
tb/sv/tb.sv
